// ----- rtl/core/kce_pkg.sv -----
// ----------------------------------------------------------------------------
// kce_pkg
// shared constants of the k-means centroid encoder
// ----------------------------------------------------------------------------
package kce_pkg;
	localparam int FEATURE_BITS = 20;
	localparam logic [FEATURE_BITS-1:0] FEATURE_MAX = '1;
	localparam logic [FEATURE_BITS-1:0] ONE_Q8 = 20'd256;

	localparam logic OP_CENTROID = 1'b0;
	localparam logic OP_PATCH = 1'b1;

	localparam int ADDR_BITS = 4;
	localparam logic [ADDR_BITS-1:0] REG_MODE = 4'h0;
	localparam logic [ADDR_BITS-1:0] REG_NUM_CENTROIDS = 4'h4;
	localparam logic [ADDR_BITS-1:0] REG_DIM_COUNT = 4'h8;

	localparam logic MODE_TRIANGLE = 1'b0;
	localparam logic MODE_HARD = 1'b1;
endpackage

// ----- rtl/core/kce_if.sv -----
// ----------------------------------------------------------------------------
// kce_in_if / kce_out_if
// valid-ready channels of the encoder
// ----------------------------------------------------------------------------
interface kce_in_if #(parameter int VALUE_BITS = 16);
	logic valid;
	logic ready;
	logic op;
	logic [5:0] centroid_index;
	logic [6:0] element_index;
	logic signed [VALUE_BITS-1:0] value;
	logic last_element;
	modport source(output valid, op, centroid_index, element_index, value, last_element,
		input ready);
	modport sink(input valid, op, centroid_index, element_index, value, last_element,
		output ready);
endinterface

interface kce_out_if;
	logic valid;
	logic ready;
	logic [5:0] centroid_number;
	logic [19:0] feature;
	logic last_feature;
	modport source(output valid, centroid_number, feature, last_feature, input ready);
	modport sink(input valid, centroid_number, feature, last_feature, output ready);
endinterface

// ----- rtl/core/kce_isqrt.sv -----
// ----------------------------------------------------------------------------
// kce_isqrt
// bit-pair iterative floor square root, saturated to the feature range
// ----------------------------------------------------------------------------
module kce_isqrt (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] radicand,
	output logic        done,
	output logic [19:0] root
);
	import kce_pkg::*;

	logic [63:0] rem_q;
	logic [31:0] root_q;
	logic [5:0]  step_q;
	logic        busy_q;
	logic [65:0] trial;
	logic [63:0] rad_q;
	logic [65:0] part;

	// restoring method: two radicand bits a step
	always_comb begin
		part = {rem_q, rad_q[63:62]};
		trial = part - {32'd0, root_q, 2'b01};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			step_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 6'd1;
				if (step_q == 6'd31) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q <= radicand;
			rem_q <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q <= {rad_q[61:0], 2'b00};
			if (!trial[65]) begin
				rem_q <= trial[63:0];
				root_q <= {root_q[30:0], 1'b1};
			end else begin
				rem_q <= part[63:0];
				root_q <= {root_q[30:0], 1'b0};
			end
		end
	end

	assign root = (root_q[31:20] != '0) ? FEATURE_MAX : root_q[19:0];
endmodule

// ----- rtl/core/kmeans_centroid_encoder_unit.sv -----
// ----------------------------------------------------------------------------
// kmeans_centroid_encoder_unit
// k-means triangle or hard encoder of one patch against stored centroids
// ----------------------------------------------------------------------------
// in: item writes a centroid element (op 0) or a patch element (op 1). a
// patch item with last_element set starts an encoding. an encoding runs
// per centroid a multiply-accumulate over dim_count elements from the
// centroid and patch memory read ports, drains the read and multiply
// stages, then runs the square root unit (start, 32 bit pair steps, done),
// then one divide bit a cycle for the mean, then emits num_centroids
// result items in centroid order, each after a distance memory read,
// then a closing step. in stays not ready meanwhile.
// out: one item per active centroid, last_feature on the last one. while
// the receiver stalls the result holds in the output register.
// config: apb, write only while idle. reset gives mode 0, 64 centroids,
// 128 dims; memories are not cleared.
// ----------------------------------------------------------------------------
module kmeans_centroid_encoder_unit #(
	parameter int MAX_CENTROIDS = 64,
	parameter int MAX_DIMS = 128,
	parameter int VALUE_BITS = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	kce_in_if.sink     in_ch,
	kce_out_if.source  out_ch,
	input  logic       psel,
	input  logic       penable,
	input  logic       pwrite,
	input  logic [kce_pkg::ADDR_BITS-1:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic       pready
);
	import kce_pkg::*;

	localparam int CB = $clog2(MAX_CENTROIDS);
	localparam int DB = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
	localparam int SUMB = FEATURE_BITS + CB;

	typedef enum logic [2:0] {ST_IDLE, ST_MAC, ST_SQRT, ST_WAIT, ST_DIV, ST_EMIT} st_t;
	st_t st_q;

	logic       mode_q;
	logic [6:0] ncent_q;
	logic [7:0] ndim_q;

	assign pready = 1'b1;
	always_comb begin
		unique case (paddr)
			REG_MODE:          prdata = {31'd0, mode_q};
			REG_NUM_CENTROIDS: prdata = {25'd0, ncent_q};
			REG_DIM_COUNT:     prdata = {24'd0, ndim_q};
			default:           prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_TRIANGLE;
			ncent_q <= 7'd64;
			ndim_q <= 8'd128;
		end else if (psel && penable && pwrite) begin
			unique case (paddr)
				REG_MODE:          mode_q <= pwdata[0];
				REG_NUM_CENTROIDS: ncent_q <= pwdata[6:0];
				REG_DIM_COUNT:     ndim_q <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	// effective counts
	logic [CB:0] n_eff;
	logic [DB:0] d_eff;
	always_comb begin
		if (ncent_q == '0) n_eff = (CB+1)'(1);
		else if (32'(ncent_q) > MAX_CENTROIDS) n_eff = (CB+1)'(MAX_CENTROIDS);
		else n_eff = (CB+1)'(ncent_q);
		if (ndim_q == '0) d_eff = (DB+1)'(1);
		else if (32'(ndim_q) > MAX_DIMS) d_eff = (DB+1)'(MAX_DIMS);
		else d_eff = (DB+1)'(ndim_q);
	end

	// memories
	logic signed [VALUE_BITS-1:0] cmem [MAX_CENTROIDS*(2**DB)];
	logic signed [VALUE_BITS-1:0] pmem [MAX_DIMS];
	logic [FEATURE_BITS-1:0] dmem [MAX_CENTROIDS];

	logic accept;
	assign in_ch.ready = (st_q == ST_IDLE);
	assign accept = in_ch.valid && in_ch.ready;

	logic c_ok, e_ok;
	assign c_ok = 32'(in_ch.centroid_index) < MAX_CENTROIDS;
	assign e_ok = 32'(in_ch.element_index) < MAX_DIMS;

	logic [CB-1:0] c_q;
	logic [DB:0]   e_q;
	logic          rd_v_s1;
	logic signed [VALUE_BITS-1:0] cr_s1, pr_s1;

	always_ff @(posedge clk) begin
		if (accept && in_ch.op == OP_CENTROID && c_ok && e_ok)
			cmem[{CB'(in_ch.centroid_index), DB'(in_ch.element_index)}] <= in_ch.value;
		if (accept && in_ch.op == OP_PATCH && e_ok)
			pmem[DB'(in_ch.element_index)] <= in_ch.value;
		cr_s1 <= cmem[{c_q, e_q[DB-1:0]}];
		pr_s1 <= pmem[e_q[DB-1:0]];
	end

	// one subtract-multiply-accumulate a cycle
	logic signed [VALUE_BITS:0] diff;
	logic [VALUE_BITS:0] mag;
	logic [2*VALUE_BITS+1:0] sq;
	logic [64:0] acc_sum;
	logic [63:0] acc_q;
	logic [63:0] sq_s2;
	logic        sq_v_s2;
	always_comb begin
		diff = (VALUE_BITS+1)'(cr_s1) - (VALUE_BITS+1)'(pr_s1);
		mag = diff[VALUE_BITS] ? (VALUE_BITS+1)'(-diff) : diff;
		sq = (2*VALUE_BITS+2)'(mag) * (2*VALUE_BITS+2)'(mag);
		acc_sum = {1'b0, acc_q} + {1'b0, sq_s2};
	end

	logic sq_start, sq_done;
	logic [FEATURE_BITS-1:0] root;
	kce_isqrt u_sqrt (.clk(clk), .arst_n(arst_n), .start(sq_start), .radicand(acc_q),
		.done(sq_done), .root(root));

	logic [SUMB-1:0] sum_q;
	logic [FEATURE_BITS-1:0] best_d_q;
	logic [CB-1:0] best_q;
	logic [SUMB-1:0] rem_q, quo_q;
	logic [5:0] dstep_q;
	logic [SUMB:0] dtrial;
	logic [FEATURE_BITS-1:0] mean_q;
	logic [FEATURE_BITS-1:0] dr_q;
	logic emit_rd_q;

	always_comb begin
		dtrial = {rem_q, quo_q[SUMB-1]} - (SUMB+1)'(n_eff);
	end

	logic ov_q;
	logic [FEATURE_BITS-1:0] feat;
	always_comb begin
		if (mode_q == MODE_TRIANGLE)
			feat = (mean_q > dr_q) ? mean_q - dr_q : '0;
		else
			feat = (c_q == best_q) ? ONE_Q8 : '0;
	end

	always_ff @(posedge clk) begin
		if (rd_v_s1) sq_s2 <= 64'(sq);
		if (st_q == ST_IDLE) begin
			acc_q <= '0;
			sum_q <= '0;
		end else if (sq_v_s2) begin
			acc_q <= acc_sum[64] ? '1 : acc_sum[63:0];
		end
		if (sq_done) begin
			dmem[c_q] <= root;
			sum_q <= sum_q + SUMB'(root);
			if (c_q == '0 || root < best_d_q) begin
				best_d_q <= root;
				best_q <= c_q;
			end
			acc_q <= '0;
		end
		if (st_q == ST_DIV) begin
			if (!dtrial[SUMB]) begin
				rem_q <= dtrial[SUMB-1:0];
				quo_q <= {quo_q[SUMB-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[SUMB-2:0], quo_q[SUMB-1]};
				quo_q <= {quo_q[SUMB-2:0], 1'b0};
			end
		end else if (st_q != ST_EMIT) begin
			rem_q <= '0;
			quo_q <= sq_done ? sum_q + SUMB'(root) : sum_q;
		end
		dr_q <= dmem[c_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			c_q <= '0;
			e_q <= '0;
			rd_v_s1 <= 1'b0;
			sq_v_s2 <= 1'b0;
			sq_start <= 1'b0;
			dstep_q <= '0;
			mean_q <= '0;
			emit_rd_q <= 1'b0;
			ov_q <= 1'b0;
			out_ch.valid <= 1'b0;
			out_ch.centroid_number <= '0;
			out_ch.feature <= '0;
			out_ch.last_feature <= 1'b0;
		end else begin
			sq_start <= 1'b0;
			rd_v_s1 <= 1'b0;
			sq_v_s2 <= rd_v_s1;
			unique case (st_q)
				ST_IDLE: begin
					c_q <= '0;
					e_q <= '0;
					if (accept && in_ch.op == OP_PATCH && in_ch.last_element)
						st_q <= ST_MAC;
				end
				ST_MAC: begin
					rd_v_s1 <= 1'b1;
					e_q <= e_q + 1'b1;
					if (e_q + 1'b1 == d_eff) st_q <= ST_WAIT;
				end
				ST_WAIT: begin
					if (!rd_v_s1 && !sq_v_s2) begin
						sq_start <= 1'b1;
						st_q <= ST_SQRT;
					end
				end
				ST_SQRT: begin
					if (sq_done) begin
						e_q <= '0;
						if ((CB+1)'(c_q) + 1'b1 == n_eff) begin
							st_q <= ST_DIV;
							dstep_q <= '0;
						end else begin
							c_q <= c_q + 1'b1;
							st_q <= ST_MAC;
						end
					end
				end
				ST_DIV: begin
					dstep_q <= dstep_q + 6'd1;
					if (32'(dstep_q) == SUMB-1) begin
						st_q <= ST_EMIT;
						c_q <= '0;
						emit_rd_q <= 1'b0;
						ov_q <= 1'b0;
					end
				end
				ST_EMIT: begin
					if (!emit_rd_q) begin
						mean_q <= (quo_q[SUMB-1:FEATURE_BITS] != '0) ? FEATURE_MAX
							: quo_q[FEATURE_BITS-1:0];
						emit_rd_q <= 1'b1;
						if (out_ch.valid && out_ch.ready)
							out_ch.valid <= 1'b0;
					end else if (!out_ch.valid || out_ch.ready) begin
						if (ov_q) begin
							out_ch.valid <= 1'b0;
							st_q <= ST_IDLE;
						end else begin
							out_ch.valid <= 1'b1;
							out_ch.centroid_number <= 6'(c_q);
							out_ch.feature <= feat;
							out_ch.last_feature <= ((CB+1)'(c_q) + 1'b1 == n_eff);
							if ((CB+1)'(c_q) + 1'b1 == n_eff) ov_q <= 1'b1;
							else begin
								c_q <= c_q + 1'b1;
								emit_rd_q <= 1'b0;
							end
						end
					end
				end
				default: st_q <= ST_IDLE;
			endcase
			if (st_q != ST_EMIT && out_ch.valid && out_ch.ready)
				out_ch.valid <= 1'b0;
		end
	end
endmodule
